FILE: design/matrix_vector_multiply_assert.svh
// assertion macros for the matrix-vector multiply block
`ifndef MATRIX_VECTOR_MULTIPLY_ASSERT_SVH
`define MATRIX_VECTOR_MULTIPLY_ASSERT_SVH

// same-cycle implication under reset
`define MVM_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("%m: check failed");

// next-cycle implication under reset
`define MVM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
		else $error("%m: check failed");

`endif

FILE: design/mvm_pkg.sv
// shared types and constants of the matrix-vector multiply block
`default_nettype none

package mvm_pkg;

	localparam int ELEM_W    = 16;
	localparam int PROD_W    = 32;
	localparam int ACC_W     = 40;
	localparam int ROW_OUT_W = 12;
	localparam int CFG_W     = 7;
	localparam int IDX_W     = 6;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 56;

	localparam logic REQ_LOAD   = 1'b0;
	localparam logic REQ_MATRIX = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MULT  = 4'b0010,
		ST_ACCUM = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic take;
		logic mult;
		logic accum;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic row_last;
	} status_t;

endpackage

`default_nettype wire

FILE: design/mvm_datapath.sv
// datapath: vector store, multiplier, saturating accumulator, result register
`default_nettype none

module mvm_datapath #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 4096
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire mvm_pkg::cmd_t                     cmd,
	output mvm_pkg::status_t                       status,
	input  wire logic                              cfg_valid,
	input  wire logic [mvm_pkg::CFG_W-1:0]         cfg_data,
	input  wire logic                              item_type,
	input  wire logic [mvm_pkg::IDX_W-1:0]         item_index,
	input  wire logic signed [mvm_pkg::ELEM_W-1:0] item_value,
	output logic signed [mvm_pkg::ACC_W-1:0]       row_sum,
	output logic [mvm_pkg::ROW_OUT_W-1:0]          row_index,
	output logic                                   saturated
);
	import mvm_pkg::*;

	localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CNT_W  = COL_W + 1;
	localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int EXT_W  = ((COL_W > IDX_W) ? COL_W : IDX_W) + 1;
	localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	logic signed [ELEM_W-1:0] vec_mem [MAX_COLS];

	logic [CFG_W-1:0]         col_count_q;
	logic [COL_W-1:0]         col_q;
	logic [ROW_W-1:0]         row_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     sat_q;
	logic signed [ELEM_W-1:0] elem_s1;
	logic signed [ELEM_W-1:0] rdata_s1;
	logic signed [PROD_W-1:0] prod_s2;

	logic [EXT_W-1:0]         idx_ext;
	logic                     idx_ok;
	logic [CMP_W-1:0]         cfg_ext;
	logic [CMP_W-1:0]         ncols;
	logic [CMP_W-1:0]         col_next;
	logic signed [ACC_W:0]    sum;
	logic signed [ACC_W-1:0]  sum_sat;
	logic                     sum_ovf;
	logic [ROW_W+ROW_OUT_W-1:0] row_ext;

	// load address range check
	assign idx_ext = EXT_W'(item_index);
	assign idx_ok  = idx_ext < EXT_W'(MAX_COLS);

	// columns in use, clamped to one..MAX_COLS
	assign cfg_ext = CMP_W'(col_count_q);
	always_comb begin
		priority if (cfg_ext == '0) begin
			ncols = CMP_W'(1);
		end else if (cfg_ext > CMP_W'(MAX_COLS)) begin
			ncols = CMP_W'(MAX_COLS);
		end else begin
			ncols = cfg_ext;
		end
	end

	assign col_next        = CMP_W'(col_q) + CMP_W'(1);
	assign status.row_last = col_next >= ncols;

	// saturating add at the accumulator width
	assign sum     = (ACC_W + 1)'(acc_q) + (ACC_W + 1)'(prod_s2);
	assign sum_ovf = sum[ACC_W] != sum[ACC_W-1];
	always_comb begin
		priority if (sum_ovf && sum[ACC_W]) begin
			sum_sat = {1'b1, {(ACC_W - 1){1'b0}}};
		end else if (sum_ovf) begin
			sum_sat = {1'b0, {(ACC_W - 1){1'b1}}};
		end else begin
			sum_sat = sum[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && item_type == REQ_LOAD && idx_ok) begin
			vec_mem[idx_ext[COL_W-1:0]] <= item_value;
		end
		if (cmd.take) begin
			rdata_s1 <= vec_mem[col_q];
			elem_s1  <= item_value;
		end
		if (cmd.mult) begin
			prod_s2 <= elem_s1 * rdata_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= CFG_W'(1);
			col_q       <= '0;
			row_q       <= '0;
			acc_q       <= '0;
			sat_q       <= 1'b0;
		end else begin
			if (cfg_valid) begin
				col_count_q <= cfg_data;
			end
			if (cmd.accum) begin
				acc_q <= sum_sat;
				if (sum_ovf) begin
					sat_q <= 1'b1;
				end
				if (status.row_last) begin
					col_q <= '0;
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			if (cmd.emit) begin
				acc_q <= '0;
				sat_q <= 1'b0;
				if (row_q == ROW_W'(MAX_ROWS - 1)) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end
		end
	end

	assign row_ext = (ROW_W + ROW_OUT_W)'(row_q);

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			row_sum   <= acc_q;
			row_index <= row_ext[ROW_OUT_W-1:0];
			saturated <= sat_q;
		end
	end

endmodule

`default_nettype wire

FILE: design/mvm_ctrl.sv
// controller: item sequencing and result handshake
`default_nettype none

module mvm_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_type,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output mvm_pkg::cmd_t         cmd,
	input  wire mvm_pkg::status_t status
);
	import mvm_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					if (in_type == REQ_MATRIX) begin
						state_d = ST_MULT;
					end
				end
			end
			ST_MULT: begin
				cmd.mult = 1'b1;
				state_d  = ST_ACCUM;
			end
			ST_ACCUM: begin
				cmd.accum = 1'b1;
				state_d   = status.row_last ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/matrix_vector_multiply.sv
// top level of the fixed-point matrix-vector multiply engine
//
// Input channel s_*: s_tuser selects the kind of item, 0 loads element_value
// into the vector store at vector_index, 1 is a matrix element in row-major
// order. Matrix element k of a row is multiplied by vector entry k and added
// into a 40-bit saturating accumulator. After the last column in use
// (cfg_data, zero counts as one, clamped to MAX_COLS) one result goes out
// on m_*: the row sum, the row index and a saturation flag.
// Configuration channel cfg_*: always ready, write it between items only.
// A load item is taken in ST_IDLE; a matrix item runs store read, multiply
// and accumulate, set by the registered store read and the multiplier
// register. The item that ends a row then moves the sum into the result
// register (waiting while a result is held); m_tvalid is set by that move.
// The result register lets the next row run while a result waits; a second
// finished row holds the input channel until m_tready takes the first.
// Reset clears the accumulator, column and row counters, sets the column
// count to one and leaves the vector store unwritten.
`default_nettype none

module matrix_vector_multiply #(
	parameter int MAX_COLS = 64,
	parameter int MAX_ROWS = 4096
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [mvm_pkg::CFG_W-1:0]           cfg_data,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// vector_index [5:0], element_value [21:6], zero [23:22]
	input  wire logic [mvm_pkg::IN_DATA_W-1:0]       s_tdata,
	// req_type [0]
	input  wire logic                                s_tuser,
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// row_sum [39:0], row_index [51:40], zero [55:52]
	output logic [mvm_pkg::OUT_DATA_W-1:0]           m_tdata,
	// saturated [0]
	output logic                                     m_tuser
);
	import mvm_pkg::*;

	cmd_t                     cmd;
	status_t                  status;
	logic signed [ACC_W-1:0]  row_sum;
	logic [ROW_OUT_W-1:0]     row_index;

	assign cfg_ready = 1'b1;

	mvm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_type   (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.status    (status)
	);

	mvm_datapath #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.item_type  (s_tuser),
		.item_index (s_tdata[IDX_W-1:0]),
		.item_value (s_tdata[IDX_W+ELEM_W-1:IDX_W]),
		.row_sum    (row_sum),
		.row_index  (row_index),
		.saturated  (m_tuser)
	);

	assign m_tdata = {{(OUT_DATA_W - ACC_W - ROW_OUT_W){1'b0}}, row_index, row_sum};

	`include "matrix_vector_multiply_assert.svh"

	// a matrix item keeps the input closed for the following cycle
	`MVM_ASSERT_NEXT(a_matrix_busy, clk, arst_n, s_tvalid && s_tready && s_tuser == REQ_MATRIX, !s_tready)
	// moving a sum into the result register raises m_tvalid
	`MVM_ASSERT_NEXT(a_emit_valid, clk, arst_n, cmd.emit, m_tvalid)
	// at most one datapath command per cycle
	`MVM_ASSERT_IMP(a_cmd_onehot, clk, arst_n, 1'b1, $onehot0(cmd))
	// a sum is never moved over a result that is still held
	`MVM_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.emit && m_tvalid, m_tready)

endmodule

`default_nettype wire
